// ----- rtl/mf3_pkg.sv -----
// Shared constants and types of the 3x3 median filter.
package mf3_pkg;

  // Pixel and window geometry.
  localparam int PIX_W      = 8;
  localparam int WIN_COLS   = 3;
  localparam int WIN_TAPS   = 9;
  localparam int CENTER_TAP = 4;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_CHANNELS  = 3;

  // Register fields and their reset values.
  localparam int WIDTH_FIELD_W    = 11;
  localparam int HEIGHT_W         = 16;
  localparam int MIN_DIM          = 3;
  localparam int DEF_IMAGE_WIDTH  = 640;
  localparam int DEF_IMAGE_HEIGHT = 480;

  // Configuration write channel.
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Window queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  // Per-window control flags that travel with each window.
  typedef struct packed {
    logic border;
    logic last;
  } mf3_flags_t;

endpackage

// ----- rtl/mf3_front.sv -----
// Front end: configuration, frame position, line stores and the 3x3 window.
module mf3_front #(
  parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH,
  parameter int CHANNELS  = mf3_pkg::DEF_CHANNELS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  s_valid_i,
  output logic                                  s_ready_o,
  input  logic [CHANNELS-1:0][mf3_pkg::PIX_W-1:0] s_pixel_i,
  input  logic                                  s_flush_i,
  input  logic [mf3_pkg::QUEUE_LVL_W-1:0]       q_level_i,
  output logic                                  q_push_o,
  output mf3_pkg::mf3_flags_t                   q_flags_o,
  output logic [mf3_pkg::WIN_TAPS-1:0][CHANNELS-1:0][mf3_pkg::PIX_W-1:0] q_win_o
);
  import mf3_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = HEIGHT_W + 1;
  localparam int PXW = CHANNELS * PIX_W;
  localparam int RESET_W = (DEF_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_IMAGE_WIDTH;

  typedef struct packed {
    logic [PXW-1:0] upper;
    logic [PXW-1:0] middle;
  } line_word_t;

  typedef logic [WIN_TAPS-1:0][CHANNELS-1:0][PIX_W-1:0] window_t;

  // Registers.
  logic [WW-1:0]       width_q, width_d;
  logic [HEIGHT_W-1:0] height_q, height_d;
  logic [AW-1:0]       col_q, col_d;
  logic [RW-1:0]       row_q, row_d;
  logic                b_valid_q;
  logic                b_wr_q;
  logic                b_produce_q;
  logic [AW-1:0]       b_addr_q;
  logic [PXW-1:0]      b_fresh_q;
  mf3_flags_t          b_flags_q;
  line_word_t          rd_q;
  window_t             win_q, win_d;
  line_word_t          line_mem [MAX_WIDTH];

  // Combinational signals.
  logic                     cfg_accept;
  logic                     accept;
  logic                     take;
  logic                     pixel_phase;
  logic                     is_last;
  logic                     produce;
  logic                     border;
  logic [WW-1:0]            col_inc;
  logic                     col_wrap;
  logic [PXW-1:0]           fresh;
  logic [WIDTH_FIELD_W-1:0] cfg_w_raw;
  logic [WW-1:0]            cfg_width;
  logic [HEIGHT_W-1:0]      cfg_height;

  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;

  // Room for this request and the one still in the window stage.
  assign s_ready_o = ({1'b0, q_level_i} + (QUEUE_LVL_W + 1)'(b_valid_q))
                     < (QUEUE_LVL_W + 1)'(QUEUE_DEPTH);
  assign accept    = s_valid_i && s_ready_o;

  // Classify the request by its place in the frame sequence.
  assign pixel_phase = row_q < RW'(height_q);
  assign take        = accept && !(pixel_phase && s_flush_i);
  assign is_last     = (row_q == (RW'(height_q) + RW'(1))) && (col_q == '0);
  assign produce     = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
  assign border      = (col_q <= AW'(1)) || (row_q == RW'(1)) || (row_q == RW'(height_q));
  assign col_inc     = WW'(col_q) + WW'(1);
  assign col_wrap    = col_inc >= width_q;
  assign fresh       = pixel_phase ? s_pixel_i : '0;

  // Clamp register writes to the supported frame sizes.
  always_comb begin
    cfg_w_raw = cfg_data_i[WIDTH_FIELD_W-1:0];
    if (cfg_w_raw < WIDTH_FIELD_W'(MIN_DIM)) begin
      cfg_width = WW'(MIN_DIM);
    end else if (int'(cfg_w_raw) > MAX_WIDTH) begin
      cfg_width = WW'(MAX_WIDTH);
    end else begin
      cfg_width = WW'(cfg_w_raw);
    end
    if (cfg_data_i[HEIGHT_W-1:0] < HEIGHT_W'(MIN_DIM)) begin
      cfg_height = HEIGHT_W'(MIN_DIM);
    end else begin
      cfg_height = cfg_data_i[HEIGHT_W-1:0];
    end
  end

  // Next frame position and register values.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_accept) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_d  = cfg_width;
        REG_IMAGE_HEIGHT: height_d = cfg_height;
        default: ;
      endcase
      col_d = '0;
      row_d = '0;
    end else if (take) begin
      if (is_last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_wrap) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_inc[AW-1:0];
      end
    end
  end

  // Shift the window left and bring in the new column.
  always_comb begin
    for (int k = 0; k < WIN_TAPS - WIN_COLS; k++) begin
      win_d[k] = win_q[k + WIN_COLS];
    end
    win_d[WIN_TAPS-3] = rd_q.upper;
    win_d[WIN_TAPS-2] = rd_q.middle;
    win_d[WIN_TAPS-1] = b_fresh_q;
  end

  assign q_push_o  = b_valid_q && b_produce_q;
  assign q_flags_o = b_flags_q;
  assign q_win_o   = win_d;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WW'(RESET_W);
      height_q  <= HEIGHT_W'(DEF_IMAGE_HEIGHT);
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      col_q     <= col_d;
      row_q     <= row_d;
      b_valid_q <= take;
    end
  end

  // Window stage payload and the sliding window.
  always_ff @(posedge clk_i) begin
    if (take) begin
      b_wr_q      <= pixel_phase;
      b_produce_q <= produce;
      b_addr_q    <= col_q;
      b_fresh_q   <= fresh;
      b_flags_q   <= '{border: border, last: is_last};
    end
    if (b_valid_q) begin
      win_q <= win_d;
    end
  end

  // Line stores: one read per taken request, the shifted word written in the next cycle.
  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_q <= line_mem[col_q];
    end
    if (b_valid_q && b_wr_q) begin
      line_mem[b_addr_q] <= '{upper: rd_q.middle, middle: b_fresh_q};
    end
  end

endmodule

// ----- rtl/mf3_queue.sv -----
// Short first-in first-out queue of windows between the front and the back.
module mf3_queue #(
  parameter int DATA_W = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [DATA_W-1:0]                data_i,
  input  logic                             pop_i,
  output logic                             valid_o,
  output logic [DATA_W-1:0]                data_o,
  output logic [mf3_pkg::QUEUE_LVL_W-1:0]  level_o
);
  import mf3_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [DATA_W-1:0]      entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QUEUE_LVL_W-1:0] count_q, count_d;
  logic                   do_pop;

  assign valid_o = count_q != '0;
  assign data_o  = entry_q[rd_ptr_q];
  assign level_o = count_q;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QUEUE_LVL_W'(push_i) - QUEUE_LVL_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/mf3_back.sv -----
// Back end: pipelined median of nine per channel and the output register.
module mf3_back #(
  parameter int CHANNELS = mf3_pkg::DEF_CHANNELS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  output logic                                  q_pop_o,
  input  mf3_pkg::mf3_flags_t                   q_flags_i,
  input  logic [mf3_pkg::WIN_TAPS-1:0][CHANNELS-1:0][mf3_pkg::PIX_W-1:0] q_win_i,
  output logic                                  m_valid_o,
  input  logic                                  m_ready_i,
  output logic [CHANNELS-1:0][mf3_pkg::PIX_W-1:0] m_pixel_o,
  output logic                                  m_last_o
);
  import mf3_pkg::*;

  typedef logic [CHANNELS-1:0][PIX_W-1:0]               pix_t;
  typedef logic [WIN_COLS-1:0][CHANNELS-1:0][PIX_W-1:0] col_t;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Stage 1: each window column sorted into minimum, median and maximum.
  col_t       s1_min_q, s1_med_q, s1_max_q;
  col_t       s1_min_d, s1_med_d, s1_max_d;
  pix_t       s1_ctr_q;
  mf3_flags_t s1_flags_q;
  logic       s1_valid_q;
  // Stage 2: largest minimum, median of medians, smallest maximum.
  pix_t       s2_lo_q, s2_mid_q, s2_hi_q;
  pix_t       s2_lo_d, s2_mid_d, s2_hi_d;
  pix_t       s2_ctr_q;
  mf3_flags_t s2_flags_q;
  logic       s2_valid_q;
  // Output register.
  pix_t       out_pix_q, out_pix_d;
  logic       out_last_q;
  logic       out_valid_q;

  logic s1_ready, s2_ready, out_ready;

  // Stall chain from the output back to the queue.
  assign out_ready = !out_valid_q || m_ready_i;
  assign s2_ready  = !s2_valid_q || out_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign q_pop_o   = q_valid_i && s1_ready;

  // Column sorts.
  always_comb begin
    for (int j = 0; j < WIN_COLS; j++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        s1_min_d[j][c] = min2(min2(q_win_i[j*WIN_COLS][c], q_win_i[j*WIN_COLS+1][c]),
                              q_win_i[j*WIN_COLS+2][c]);
        s1_max_d[j][c] = max2(max2(q_win_i[j*WIN_COLS][c], q_win_i[j*WIN_COLS+1][c]),
                              q_win_i[j*WIN_COLS+2][c]);
        s1_med_d[j][c] = med3(q_win_i[j*WIN_COLS][c], q_win_i[j*WIN_COLS+1][c],
                              q_win_i[j*WIN_COLS+2][c]);
      end
    end
  end

  // Reduce the sorted columns to three candidates.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      s2_lo_d[c]  = max2(max2(s1_min_q[0][c], s1_min_q[1][c]), s1_min_q[2][c]);
      s2_mid_d[c] = med3(s1_med_q[0][c], s1_med_q[1][c], s1_med_q[2][c]);
      s2_hi_d[c]  = min2(min2(s1_max_q[0][c], s1_max_q[1][c]), s1_max_q[2][c]);
    end
  end

  // Median of the candidates, or the centre pixel on the border ring.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      out_pix_d[c] = s2_flags_q.border ? s2_ctr_q[c]
                                       : med3(s2_lo_q[c], s2_mid_q[c], s2_hi_q[c]);
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= q_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_min_q   <= s1_min_d;
      s1_med_q   <= s1_med_d;
      s1_max_q   <= s1_max_d;
      s1_ctr_q   <= q_win_i[CENTER_TAP];
      s1_flags_q <= q_flags_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_lo_q    <= s2_lo_d;
      s2_mid_q   <= s2_mid_d;
      s2_hi_q    <= s2_hi_d;
      s2_ctr_q   <= s1_ctr_q;
      s2_flags_q <= s1_flags_q;
    end
    if (out_ready && s2_valid_q) begin
      out_pix_q  <= out_pix_d;
      out_last_q <= s2_flags_q.last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_pixel_o = out_pix_q;
  assign m_last_o  = out_last_q;

endmodule

// ----- rtl/median_filter_3x3_rgb_unit.sv -----
// Top level of the streaming 3x3 median filter over multi-channel pixels.
//
//   Channel   Direction  Signals                           Carries
//   s_axis    in         tvalid tready tdata tuser         one pixel or drain request
//   m_axis    out        tvalid tready tdata tlast         one filtered pixel
//   cfg       in         valid ready index data            register write
//
// One request is taken every clock cycle while tready is high; the rate is set by
// the line store, which is read once per request and written back in the next cycle.
// A completed window passes the window stage, the window queue and the back stages
// to the output register; the image lags the input by one row plus one pixel.
// Reset clears control state only; the line stores hold no valid bits and
// need no clearing pass. A stalled output fills the three back stages and then
// the four-entry window queue; tready falls once the queue and the window stage
// together hold four windows. The input side never stalls the output side.
module median_filter_3x3_rgb_unit #(
  parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH,
  parameter int CHANNELS  = mf3_pkg::DEF_CHANNELS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input pixels.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [CHANNELS*mf3_pkg::PIX_W-1:0]    s_axis_tdata,  // pixel_ch0, pixel_ch1, ...
  input  logic                                  s_axis_tuser,  // flush
  // Filtered pixels.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [CHANNELS*mf3_pkg::PIX_W-1:0]    m_axis_tdata,  // out_ch0, out_ch1, ...
  output logic                                  m_axis_tlast,  // end_of_frame
  // Register writes.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import mf3_pkg::*;

  localparam int QW = $bits(mf3_flags_t) + WIN_TAPS * CHANNELS * PIX_W;

  logic [CHANNELS-1:0][PIX_W-1:0]               in_pix;
  logic [CHANNELS-1:0][PIX_W-1:0]               out_pix;
  logic                                         q_push;
  logic                                         q_pop;
  logic                                         q_valid;
  logic [QUEUE_LVL_W-1:0]                       q_level;
  mf3_flags_t                                   wr_flags, rd_flags;
  logic [WIN_TAPS-1:0][CHANNELS-1:0][PIX_W-1:0] wr_win, rd_win;
  logic [QW-1:0]                                q_wdata, q_rdata;

  assign in_pix       = s_axis_tdata;
  assign m_axis_tdata = out_pix;

  // Front: position tracking, line stores and window.
  mf3_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CHANNELS  (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_pixel_i   (in_pix),
    .s_flush_i   (s_axis_tuser),
    .q_level_i   (q_level),
    .q_push_o    (q_push),
    .q_flags_o   (wr_flags),
    .q_win_o     (wr_win)
  );

  assign q_wdata            = {wr_flags, wr_win};
  assign {rd_flags, rd_win} = q_rdata;

  // Window queue.
  mf3_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .level_o (q_level)
  );

  // Back: median network and output register.
  mf3_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_flags_i (rd_flags),
    .q_win_i   (rd_win),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_pixel_o (out_pix),
    .m_last_o  (m_axis_tlast)
  );

endmodule
